// ===== hdl/tkms_pkg.sv =====
// Package for the type-keyed multi-stack: field widths, default sizes,
// result status codes and the control-state encoding.
// No dependencies; every other file of the block imports it.
`default_nettype none

package tkms_pkg;

	// Beat field widths.
	localparam int FUNC_W     = 1;
	localparam int KEY_W      = 16;
	localparam int PAYLOAD_W  = 32;
	localparam int STATUS_W   = 3;
	localparam int NONEMPTY_W = 4;

	// Default sizes handed to the top level.
	localparam int NUM_TYPES_DEF   = 8;
	localparam int STACK_DEPTH_DEF = 16;

	// Operation codes on the func field.
	localparam logic [FUNC_W-1:0] FUNC_PUSH = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_POP  = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_PUSHED     = 3'd0,
		ST_POPPED     = 3'd1,
		ST_EMPTY      = 3'd2,
		ST_TABLE_FULL = 3'd3,
		ST_STACK_FULL = 3'd4
	} status_t;

	// Control states of the sequencer.
	typedef enum logic [1:0] {
		FS_IDLE,
		FS_EXEC,
		FS_FIN
	} fsm_t;

	// Action decided by the type table for one operation.
	typedef struct packed {
		logic    wr;      // push goes into the stack memory
		logic    rd;      // pop reads the stack memory
		status_t status;
	} act_t;

endpackage

`default_nettype wire

// ===== hdl/tkms_req_if.sv =====
// Request channel of the type-keyed multi-stack: valid/ready plus the
// operation, type key and payload. Depends on tkms_pkg.
`default_nettype none

interface tkms_req_if import tkms_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [FUNC_W-1:0]    func;
	logic [KEY_W-1:0]     type_code;
	logic [PAYLOAD_W-1:0] payload;

	modport source (output valid, output func, output type_code, output payload,
		input ready);
	modport sink (input valid, input func, input type_code, input payload,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/tkms_rsp_if.sv =====
// Response channel of the type-keyed multi-stack: valid/ready plus status,
// popped payload and non-empty stack count. Depends on tkms_pkg.
`default_nettype none

interface tkms_rsp_if import tkms_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [PAYLOAD_W-1:0]  popped_payload;
	logic [NONEMPTY_W-1:0] nonempty_stacks;

	modport source (output valid, output status, output popped_payload,
		output nonempty_stacks, input ready);
	modport sink (input valid, input status, input popped_payload,
		input nonempty_stacks, output ready);
endinterface

`default_nettype wire

// ===== hdl/tkms_stack_mem.sv =====
// Stack storage of the type-keyed multi-stack: one synchronous memory,
// one write or one read per cycle, registered read data. Depends on tkms_pkg.
`default_nettype none

module tkms_stack_mem import tkms_pkg::*; #(
	parameter int DEPTH = NUM_TYPES_DEF * STACK_DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic                 rd_en,
	input  wire logic [AW-1:0]        addr,
	input  wire logic [PAYLOAD_W-1:0] wr_data,
	output logic      [PAYLOAD_W-1:0] rd_data
);

	logic [PAYLOAD_W-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tkms_type_table.sv =====
// Type table of the type-keyed multi-stack: keys, in-use bits, stack levels
// and the count of non-empty stacks, with the push/pop decision logic.
// Depends on tkms_pkg.
`default_nettype none

module tkms_type_table import tkms_pkg::*; #(
	parameter int NUM_TYPES   = NUM_TYPES_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int AW          = (NUM_TYPES * STACK_DEPTH > 1) ?
		$clog2(NUM_TYPES * STACK_DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  exec,
	input  wire logic [FUNC_W-1:0]     func,
	input  wire logic [KEY_W-1:0]      key,
	output act_t                       act,
	output logic      [AW-1:0]         addr,
	output logic      [NONEMPTY_W-1:0] nonempty
);

	localparam int SW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(NUM_TYPES + 1);

	logic [KEY_W-1:0] keys_q   [NUM_TYPES];
	logic [LW-1:0]    level_q  [NUM_TYPES];
	logic [NUM_TYPES-1:0] in_use_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_d;

	logic          hit;
	logic [SW-1:0] hit_idx;
	logic          free_found;
	logic [SW-1:0] free_idx;
	logic          alloc;
	logic [SW-1:0] slot;
	logic [LW-1:0] lvl;
	logic [IW-1:0] idx;

	// Key match and first-free search; the lowest index wins in both.
	always_comb begin
		hit        = 1'b0;
		hit_idx    = '0;
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_TYPES - 1; i >= 0; i--) begin
			if (in_use_q[i] && keys_q[i] == key) begin
				hit     = 1'b1;
				hit_idx = SW'(i);
			end
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	// Decision for the operation and the stack memory address.
	always_comb begin
		act.wr     = 1'b0;
		act.rd     = 1'b0;
		act.status = ST_EMPTY;
		alloc      = 1'b0;
		slot       = hit ? hit_idx : free_idx;
		lvl        = level_q[slot];
		idx        = lvl[IW-1:0];
		if (func == FUNC_PUSH) begin
			alloc = !hit && free_found;
			if (!hit && !free_found) begin
				act.status = ST_TABLE_FULL;
			end else if (lvl >= LW'(STACK_DEPTH)) begin
				act.status = ST_STACK_FULL;
			end else begin
				act.status = ST_PUSHED;
				act.wr     = 1'b1;
			end
		end else begin
			idx = IW'(lvl - LW'(1));
			if (hit && lvl != '0) begin
				act.status = ST_POPPED;
				act.rd     = 1'b1;
			end
		end
		addr = AW'(slot) * AW'(STACK_DEPTH) + AW'(idx);
	end

	// Non-empty count after this operation.
	always_comb begin
		count_d = count_q;
		if (act.wr && lvl == '0) begin
			count_d = count_q + CW'(1);
		end else if (act.rd && lvl == LW'(1)) begin
			count_d = count_q - CW'(1);
		end
	end

	assign nonempty = NONEMPTY_W'(count_d);

	// Table keys carry no reset; the in-use bits gate them.
	always_ff @(posedge clk) begin
		if (exec && alloc) begin
			keys_q[slot] <= key;
		end
	end

	// Control state of the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			count_q  <= '0;
			for (int i = 0; i < NUM_TYPES; i++) begin
				level_q[i] <= '0;
			end
		end else if (exec) begin
			if (alloc) begin
				in_use_q[slot] <= 1'b1;
			end
			if (act.wr) begin
				level_q[slot] <= lvl + LW'(1);
			end else if (act.rd) begin
				level_q[slot] <= lvl - LW'(1);
			end
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/type_keyed_multi_stack.sv =====
// Channel  Dir  Beat fields                                    Handshake
// req      in   func, type_code, payload                       valid/ready
// rsp      out  status, popped_payload, nonempty_stacks        valid/ready
//
// Each item goes through the EXEC state, for the type table lookup and the
// memory write or read, then FIN, where the registered memory read data
// is loaded to the output. The next request is taken in the cycle the
// result is loaded while rsp is drained; none is taken during EXEC.
// A stalled rsp holds the result and the next request waits behind it.
// Reset clears the type table and levels at once; no clearing pass is needed.
// Top level of the type-keyed multi-stack. Depends on tkms_pkg, tkms_req_if,
// tkms_rsp_if, tkms_type_table and tkms_stack_mem.
`default_nettype none

module type_keyed_multi_stack import tkms_pkg::*; #(
	parameter int NUM_TYPES   = NUM_TYPES_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	tkms_req_if.sink    req,
	tkms_rsp_if.source  rsp
);

	localparam int DEPTH = NUM_TYPES * STACK_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	fsm_t state_q;
	fsm_t state_d;

	logic                  accept;
	logic                  exec;
	logic                  load;
	logic                  out_free;

	logic [FUNC_W-1:0]     func_s1;
	logic [KEY_W-1:0]      key_s1;
	logic [PAYLOAD_W-1:0]  payload_s1;

	act_t                  act;
	logic [AW-1:0]         addr;
	logic [NONEMPTY_W-1:0] nonempty;
	logic [PAYLOAD_W-1:0]  rd_data;

	status_t               status_s2;
	logic                  pop_s2;
	logic [NONEMPTY_W-1:0] nonempty_s2;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [PAYLOAD_W-1:0]  out_popped_q;
	logic [NONEMPTY_W-1:0] out_nonempty_q;

	assign out_free = !out_valid_q || rsp.ready;

	// Sequencer: next state and handshake controls.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		exec      = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			FS_IDLE: begin
				req.ready = 1'b1;
			end
			FS_EXEC: begin
				exec    = 1'b1;
				state_d = FS_FIN;
			end
			FS_FIN: begin
				if (out_free) begin
					load      = 1'b1;
					req.ready = 1'b1;
					state_d   = FS_IDLE;
				end
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
		accept = req.valid && req.ready;
		if (accept) begin
			state_d = FS_EXEC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the request beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1    <= req.func;
			key_s1     <= req.type_code;
			payload_s1 <= req.payload;
		end
	end

	tkms_type_table #(
		.NUM_TYPES   (NUM_TYPES),
		.STACK_DEPTH (STACK_DEPTH),
		.AW          (AW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.exec     (exec),
		.func     (func_s1),
		.key      (key_s1),
		.act      (act),
		.addr     (addr),
		.nonempty (nonempty)
	);

	tkms_stack_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (exec && act.wr),
		.rd_en   (exec && act.rd),
		.addr    (addr),
		.wr_data (payload_s1),
		.rd_data (rd_data)
	);

	// Hold the decision while the memory read completes.
	always_ff @(posedge clk) begin
		if (exec) begin
			status_s2   <= act.status;
			pop_s2      <= act.rd;
			nonempty_s2 <= nonempty;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q   <= status_s2;
			out_popped_q   <= pop_s2 ? rd_data : '0;
			out_nonempty_q <= nonempty_s2;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.popped_payload  = out_popped_q;
	assign rsp.nonempty_stacks = out_nonempty_q;

endmodule

`default_nettype wire
